// ===== hdl/frpc_pkg.sv =====
// ----------------------------------------------------------------------------
// frpc_pkg
// Shared types, codes and constant tables for the framed RPC message parser.
// ----------------------------------------------------------------------------
`default_nettype none

package frpc_pkg;

   // Header layout, in byte positions within the 12-byte header
   localparam int unsigned SIZE_LAST = 3;
   localparam int unsigned TYPE_HIGH = 6;
   localparam int unsigned TYPE_LOW  = 7;
   localparam int unsigned MLEN_FIRST = 8;
   localparam int unsigned HDR_LAST  = 11;
   localparam int unsigned HDR_BYTES = 12;
   localparam int unsigned SEQ_LAST  = 3;

   // Length of the fixed heartbeat method name
   localparam int unsigned HB_LEN = 17;

   // Message type codes
   localparam logic [15:0] T_CALL   = 16'd1;
   localparam logic [15:0] T_REPLY  = 16'd2;
   localparam logic [15:0] T_NOTIFY = 16'd4;

   // Byte role codes
   localparam logic [2:0] ROLE_HEADER  = 3'd0;
   localparam logic [2:0] ROLE_METHOD  = 3'd1;
   localparam logic [2:0] ROLE_SEQ     = 3'd2;
   localparam logic [2:0] ROLE_BODY    = 3'd3;
   localparam logic [2:0] ROLE_DISCARD = 3'd4;

   // Frame kind codes
   localparam logic [1:0] KIND_NONE     = 2'd0;
   localparam logic [1:0] KIND_REQUEST  = 2'd1;
   localparam logic [1:0] KIND_RESPONSE = 2'd2;

   // Status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_BAD_TYPE = 2'd1;
   localparam logic [1:0] STAT_BAD_LEN  = 2'd2;

   typedef enum logic [4:0] {
      PH_HEADER  = 5'b00001,
      PH_METHOD  = 5'b00010,
      PH_SEQ     = 5'b00100,
      PH_BODY    = 5'b01000,
      PH_DISCARD = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [2:0]  byte_role;
      logic [1:0]  frame_kind;
      logic        is_heartbeat;
      logic [31:0] sequence_id;
      logic        frame_end;
      logic [1:0]  status;
   } rsp_payload_type;

   // Heartbeat method name, lower case, one character per position
   function automatic logic [7:0] hb_char(input logic [4:0] idx);
      logic [7:0] c;
      case (idx)
         5'd0:    c = "a";
         5'd1:    c = "l";
         5'd2:    c = "l";
         5'd3:    c = "s";
         5'd4:    c = "p";
         5'd5:    c = "a";
         5'd6:    c = "r";
         5'd7:    c = "k";
         5'd8:    c = "h";
         5'd9:    c = "e";
         5'd10:   c = "a";
         5'd11:   c = "r";
         5'd12:   c = "t";
         5'd13:   c = "b";
         5'd14:   c = "e";
         5'd15:   c = "a";
         5'd16:   c = "t";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= "A" && c <= "Z") begin
         r = c + 8'd32;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/frpc_stream_if.sv =====
// ----------------------------------------------------------------------------
// frpc_stream_if
// Valid/ready channels for the parser: request bytes in, tagged bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface frpc_req_if;
   logic                      valid;
   logic                      ready;
   frpc_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface frpc_rsp_if;
   logic                      valid;
   logic                      ready;
   frpc_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/framed_rpc_message_parser_unit.sv =====
// State updates in the accept cycle; its response is valid the next cycle.
// Throughput: one byte per clock while responses are taken; a new byte
// enters in the same cycle the previous response is taken.
// Reset (synchronous, active high): parser returns to the header phase with
// the sticky error cleared; the response register is emptied.
// ----------------------------------------------------------------------------
// framed_rpc_message_parser_unit
// Byte-stream parser for framed binary RPC messages. Each byte is passed
// through and tagged with its role, the frame kind, heartbeat match,
// sequence id, end-of-frame flag and sticky status.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_rpc_message_parser_unit (
   input wire logic      clock,
   input wire logic      reset,
   frpc_req_if.sink      req_chan,
   frpc_rsp_if.source    rsp_chan
);

   // ---------------------------------------------------------------------
   // Parse state
   // ---------------------------------------------------------------------
   frpc_pkg::phase_type phase_ff, phase_in;
   logic [31:0] count_ff, count_in;      // byte count within current field
   logic [31:0] size_ff, size_in;        // frame size word from header
   logic [31:0] mlen_ff, mlen_in;        // method name length from header
   logic [31:0] body_len_ff, body_len_in;
   logic [1:0]  kind_ff, kind_in;
   logic        hb_ff, hb_in;            // name still matches so far
   logic [31:0] seq_ff, seq_in;
   logic [1:0]  err_ff, err_in;          // sticky until reset
   logic [7:0]  type_hi_ff, type_hi_in;

   // Response register
   logic                      rsp_valid_ff, rsp_valid_in;
   frpc_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   // ---------------------------------------------------------------------
   // Handshake: take a byte whenever the response register is free or is
   // being drained in this same cycle.
   // ---------------------------------------------------------------------
   logic accept;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // Body length is registered from size and method length; both are
   // stable from the last header byte, well before the last sequence byte.
   assign body_len_in = size_ff - mlen_ff - 32'(frpc_pkg::HDR_BYTES);

   // ---------------------------------------------------------------------
   // Per-byte decode
   // ---------------------------------------------------------------------
   logic [7:0]                b;
   logic [31:0]               count_inc;
   logic [31:0]               mlen_shift;
   logic [31:0]               seq_shift;
   logic [15:0]               msg_type;
   logic                      mlen_is_hb;
   logic                      hb_now;
   logic                      hb_upd;
   logic                      name_miss;
   logic                      len_short;
   logic                      end_frame;
   frpc_pkg::rsp_payload_type res;

   always_comb begin
      b          = req_chan.payload.data_byte;
      count_inc  = count_ff + 32'd1;
      mlen_shift = {mlen_ff[23:0], b};
      seq_shift  = {seq_ff[23:0], b};
      msg_type   = {type_hi_ff, b};
      mlen_is_hb = (mlen_ff == 32'(frpc_pkg::HB_LEN));
      hb_now     = hb_ff && mlen_is_hb;
      // Size must cover the whole header plus the method name
      len_short  = {1'b0, size_ff} < (33'(frpc_pkg::HDR_BYTES) + {1'b0, mlen_shift});
      // Any name position past the fixed name length is a miss
      name_miss  = (count_ff >= 32'(frpc_pkg::HB_LEN)) ||
                   (frpc_pkg::to_lower(b) != frpc_pkg::hb_char(count_ff[4:0]));
      hb_upd     = hb_ff && !name_miss;

      phase_in   = phase_ff;
      count_in   = count_ff;
      size_in    = size_ff;
      mlen_in    = mlen_ff;
      kind_in    = kind_ff;
      hb_in      = hb_ff;
      seq_in     = seq_ff;
      err_in     = err_ff;
      type_hi_in = type_hi_ff;
      end_frame  = 1'b0;

      res          = '0;
      res.out_byte = b;

      unique case (phase_ff)
         frpc_pkg::PH_HEADER: begin
            res.byte_role = frpc_pkg::ROLE_HEADER;
            if (count_ff[3:0] <= 4'(frpc_pkg::SIZE_LAST)) begin
               size_in = {size_ff[23:0], b};
            end else if (count_ff[3:0] == 4'(frpc_pkg::TYPE_HIGH)) begin
               type_hi_in = b;
            end else if (count_ff[3:0] == 4'(frpc_pkg::TYPE_LOW)) begin
               if (msg_type == frpc_pkg::T_CALL || msg_type == frpc_pkg::T_NOTIFY) begin
                  kind_in = frpc_pkg::KIND_REQUEST;
               end else if (msg_type == frpc_pkg::T_REPLY) begin
                  kind_in = frpc_pkg::KIND_RESPONSE;
               end else begin
                  kind_in = frpc_pkg::KIND_NONE;
                  err_in  = frpc_pkg::STAT_BAD_TYPE;
               end
            end else if (count_ff[3:0] >= 4'(frpc_pkg::MLEN_FIRST)) begin
               mlen_in = mlen_shift;
            end
            count_in       = count_inc;
            res.frame_kind = kind_in;
            if (err_in != frpc_pkg::STAT_OK) begin
               phase_in       = frpc_pkg::PH_DISCARD;
               res.frame_kind = frpc_pkg::KIND_NONE;
            end else if (count_ff[3:0] == 4'(frpc_pkg::HDR_LAST)) begin
               if (len_short) begin
                  err_in   = frpc_pkg::STAT_BAD_LEN;
                  phase_in = frpc_pkg::PH_DISCARD;
               end else begin
                  count_in = '0;
                  // Empty method name skips straight to the sequence id
                  phase_in = (mlen_shift == '0) ? frpc_pkg::PH_SEQ : frpc_pkg::PH_METHOD;
               end
            end
         end
         frpc_pkg::PH_METHOD: begin
            res.byte_role  = frpc_pkg::ROLE_METHOD;
            res.frame_kind = kind_ff;
            hb_in          = hb_upd;
            count_in       = count_inc;
            if (count_inc == mlen_ff) begin
               phase_in         = frpc_pkg::PH_SEQ;
               count_in         = '0;
               res.is_heartbeat = hb_upd && mlen_is_hb;
            end
         end
         frpc_pkg::PH_SEQ: begin
            res.byte_role    = frpc_pkg::ROLE_SEQ;
            res.frame_kind   = kind_ff;
            res.is_heartbeat = hb_now;
            seq_in           = seq_shift;
            count_in         = count_inc;
            if (count_ff[1:0] == 2'(frpc_pkg::SEQ_LAST)) begin
               res.sequence_id = seq_shift;
               count_in        = '0;
               // Empty body: the frame ends on the last sequence byte
               if (body_len_ff == '0) begin
                  end_frame = 1'b1;
               end else begin
                  phase_in = frpc_pkg::PH_BODY;
               end
            end
         end
         frpc_pkg::PH_BODY: begin
            res.byte_role    = frpc_pkg::ROLE_BODY;
            res.frame_kind   = kind_ff;
            res.is_heartbeat = hb_now;
            res.sequence_id  = seq_ff;
            count_in         = count_inc;
            if (count_inc == body_len_ff) begin
               end_frame = 1'b1;
            end
         end
         frpc_pkg::PH_DISCARD: begin
            res.byte_role = frpc_pkg::ROLE_DISCARD;
         end
         default: begin
            res.byte_role = frpc_pkg::ROLE_DISCARD;
            phase_in      = frpc_pkg::PH_DISCARD;
         end
      endcase

      // Frame done: clear per-frame state, keep the sticky error
      if (end_frame) begin
         phase_in   = frpc_pkg::PH_HEADER;
         count_in   = '0;
         size_in    = '0;
         mlen_in    = '0;
         kind_in    = frpc_pkg::KIND_NONE;
         hb_in      = 1'b1;
         seq_in     = '0;
         type_hi_in = '0;
      end

      res.frame_end = end_frame;
      res.status    = err_in;
   end

   // Response register next value
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= frpc_pkg::PH_HEADER;
         count_ff     <= '0;
         size_ff      <= '0;
         mlen_ff      <= '0;
         kind_ff      <= frpc_pkg::KIND_NONE;
         hb_ff        <= 1'b1;
         seq_ff       <= '0;
         err_ff       <= frpc_pkg::STAT_OK;
         type_hi_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff   <= phase_in;
            count_ff   <= count_in;
            size_ff    <= size_in;
            mlen_ff    <= mlen_in;
            kind_ff    <= kind_in;
            hb_ff      <= hb_in;
            seq_ff     <= seq_in;
            err_ff     <= err_in;
            type_hi_ff <= type_hi_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers, no reset needed
   always_ff @(posedge clock) begin
      body_len_ff <= body_len_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== dv/framed_rpc_message_parser_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_rpc_message_parser_unit_test
// Self-checking bench for the framed RPC byte-stream parser. Frames are built
// byte by byte into a queue, sent under random bursts and gaps, and every
// tagged byte that comes back is checked field by field against a parser
// model kept in step with the accepted input.
// ----------------------------------------------------------------------------

module framed_rpc_message_parser_unit_test;

   localparam int CLK_HALF     = 5;
   localparam int RESET_CYCLES = 5;
   localparam int STREAM_BYTES = 540;   // well-formed part of the stream
   localparam int CYCLE_LIMIT  = 100000;
   localparam int DRAIN_CYCLES = 8;     // margin after the last expected response
   localparam int HOLD_AT      = 150;   // responses seen before the long hold-off
   localparam int HOLD_CYCLES  = 400;
   localparam int REPORT_LINES = 40;

   // Heartbeat method name, lower case, first character in the top byte
   localparam logic [8*frpc_pkg::HB_LEN-1:0] HB_NAME = {"alls", "park", "heart", "beat"};

   typedef enum int {
      NAME_EMPTY,
      NAME_HEARTBEAT,   // right name, random letter case
      NAME_ALTERED,     // 17 bytes, one position wrong
      NAME_LONG,        // heartbeat name followed by extra bytes
      NAME_SHORT,       // proper prefix of the heartbeat name
      NAME_RANDOM
   } name_form_type;

   typedef struct packed {
      logic [7:0] data;
      logic       drain_first;   // hold this byte back until all results are in
   } stim_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   frpc_req_if req_chan ();
   frpc_rsp_if rsp_chan ();

   framed_rpc_message_parser_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #(CLK_HALF) clock = ~clock;

   // Stimulus
   stim_byte_type stream_bytes[$];
   logic [7:0]    name_buf[$];
   bit            drain_next = 1'b0;

   // Parser model state
   frpc_pkg::phase_type parse_stage;
   logic [31:0] field_pos;
   logic [31:0] size_acc;
   logic [31:0] mlen_acc;
   logic [1:0]  kind_acc;
   logic        name_ok;
   logic [31:0] seqid_acc;
   logic [7:0]  type_msb;
   logic [1:0]  err_code;

   // Tagged bytes still owed by the block, oldest first
   frpc_pkg::rsp_payload_type tags_due[$];

   int   cycle_count = 0;
   int   error_count = 0;
   int   rsp_seen    = 0;
   logic req_fire    = 1'b0;

   // Sender burst/gap and receiver stall state
   int          burst_left  = 8;
   int          gap_left    = 0;
   int          hold_left   = 0;
   bit          hold_done   = 1'b0;
   logic [15:0] stall_mask  = '1;
   logic [3:0]  stall_phase = '0;

   // ------------------------------------------------------------------------
   // Parser model
   // ------------------------------------------------------------------------
   task automatic restart_frame();
      parse_stage = frpc_pkg::PH_HEADER;
      field_pos   = '0;
      size_acc    = '0;
      mlen_acc    = '0;
      kind_acc    = frpc_pkg::KIND_NONE;
      name_ok     = 1'b1;
      seqid_acc   = '0;
      type_msb    = '0;
   endtask

   // Tag one accepted byte and queue the expected response.
   task automatic parse_byte(input logic [7:0] b);
      frpc_pkg::rsp_payload_type tag;
      logic [31:0]     pos;
      logic [31:0]     body_len;
      logic [15:0]     msg_type;
      logic [7:0]      lc;
      logic            hb_held;

      tag          = '0;
      tag.out_byte = b;
      pos          = field_pos;
      // heartbeat flag as it stood before this byte; only used past the name
      hb_held      = name_ok && (mlen_acc == frpc_pkg::HB_LEN);
      body_len     = size_acc - frpc_pkg::HDR_BYTES - mlen_acc;

      case (parse_stage)
         frpc_pkg::PH_HEADER: begin
            tag.byte_role = frpc_pkg::ROLE_HEADER;
            if (pos <= frpc_pkg::SIZE_LAST) begin
               size_acc = {size_acc[23:0], b};
            end else if (pos == frpc_pkg::TYPE_HIGH) begin
               type_msb = b;
            end else if (pos == frpc_pkg::TYPE_LOW) begin
               msg_type = {type_msb, b};
               if (msg_type == frpc_pkg::T_CALL || msg_type == frpc_pkg::T_NOTIFY) begin
                  kind_acc = frpc_pkg::KIND_REQUEST;
               end else if (msg_type == frpc_pkg::T_REPLY) begin
                  kind_acc = frpc_pkg::KIND_RESPONSE;
               end else begin
                  kind_acc = frpc_pkg::KIND_NONE;
                  err_code = frpc_pkg::STAT_BAD_TYPE;
               end
            end else if (pos >= frpc_pkg::MLEN_FIRST) begin
               mlen_acc = {mlen_acc[23:0], b};
            end
            field_pos      = pos + 32'd1;
            tag.frame_kind = kind_acc;
            if (err_code != frpc_pkg::STAT_OK) begin
               parse_stage    = frpc_pkg::PH_DISCARD;
               tag.frame_kind = frpc_pkg::KIND_NONE;
            end else if (pos == frpc_pkg::HDR_LAST) begin
               // size check is done without 32-bit wrap
               if ({32'd0, size_acc} < 64'(frpc_pkg::HDR_BYTES) + {32'd0, mlen_acc}) begin
                  err_code    = frpc_pkg::STAT_BAD_LEN;
                  parse_stage = frpc_pkg::PH_DISCARD;
               end else begin
                  field_pos   = '0;
                  parse_stage = (mlen_acc == 32'd0) ? frpc_pkg::PH_SEQ : frpc_pkg::PH_METHOD;
               end
            end
         end
         frpc_pkg::PH_METHOD: begin
            tag.byte_role = frpc_pkg::ROLE_METHOD;
            lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
            if (pos >= frpc_pkg::HB_LEN ||
                lc != HB_NAME[8*(frpc_pkg::HB_LEN-1-pos) +: 8]) begin
               name_ok = 1'b0;
            end
            field_pos      = pos + 32'd1;
            tag.frame_kind = kind_acc;
            if (field_pos == mlen_acc) begin
               parse_stage      = frpc_pkg::PH_SEQ;
               field_pos        = '0;
               tag.is_heartbeat = name_ok && (mlen_acc == frpc_pkg::HB_LEN);
            end
         end
         frpc_pkg::PH_SEQ: begin
            tag.byte_role    = frpc_pkg::ROLE_SEQ;
            seqid_acc        = {seqid_acc[23:0], b};
            field_pos        = pos + 32'd1;
            tag.frame_kind   = kind_acc;
            tag.is_heartbeat = hb_held;
            if (field_pos == frpc_pkg::SEQ_LAST + 1) begin
               tag.sequence_id = seqid_acc;
               field_pos       = '0;
               // empty body: the frame ends on the last sequence id byte
               if (body_len == 32'd0) begin
                  tag.frame_end = 1'b1;
               end else begin
                  parse_stage = frpc_pkg::PH_BODY;
               end
            end
         end
         frpc_pkg::PH_BODY: begin
            tag.byte_role    = frpc_pkg::ROLE_BODY;
            field_pos        = pos + 32'd1;
            tag.frame_kind   = kind_acc;
            tag.is_heartbeat = hb_held;
            tag.sequence_id  = seqid_acc;
            if (field_pos == body_len) begin
               tag.frame_end = 1'b1;
            end
         end
         default: begin
            // sticky error: everything is dropped until reset
            tag.byte_role = frpc_pkg::ROLE_DISCARD;
            parse_stage   = frpc_pkg::PH_DISCARD;
         end
      endcase

      if (tag.frame_end) begin
         restart_frame();
      end
      tag.status = err_code;
      tags_due.push_back(tag);
   endtask

   // ------------------------------------------------------------------------
   // Frame builders
   // ------------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b);
      stream_bytes.push_back('{data: b, drain_first: drain_next});
      drain_next = 1'b0;
   endtask

   // Big-endian, n bytes
   task automatic push_word(input logic [31:0] w, input int n);
      for (int i = n - 1; i >= 0; i--) begin
         push_byte(w[8*i +: 8]);
      end
   endtask

   task automatic add_header(input logic [31:0] size, input logic [15:0] version,
                             input logic [15:0] msg_type, input logic [31:0] mlen);
      push_word(size, 4);
      push_word(32'(version), 2);
      push_word(32'(msg_type), 2);
      push_word(mlen, 4);
   endtask

   task automatic make_name(input name_form_type form);
      logic [7:0] c;
      int         pos;

      name_buf.delete();
      case (form)
         NAME_EMPTY: begin
         end
         NAME_RANDOM: begin
            repeat ($urandom_range(1, 24)) name_buf.push_back(8'($urandom));
         end
         default: begin
            for (int i = 0; i < frpc_pkg::HB_LEN; i++) begin
               c = HB_NAME[8*(frpc_pkg::HB_LEN-1-i) +: 8];
               if ($urandom_range(0, 1) == 1) begin
                  c = c - 8'd32;
               end
               name_buf.push_back(c);
            end
            if (form == NAME_ALTERED) begin
               pos = int'($urandom_range(0, frpc_pkg::HB_LEN - 1));
               c   = 8'($urandom);
               // either case of the right letter would still match
               if (c == HB_NAME[8*(frpc_pkg::HB_LEN-1-pos) +: 8] ||
                   c == HB_NAME[8*(frpc_pkg::HB_LEN-1-pos) +: 8] - 8'd32) begin
                  c = c ^ 8'h01;
               end
               name_buf[pos] = c;
            end else if (form == NAME_LONG) begin
               repeat ($urandom_range(1, 8)) name_buf.push_back(8'($urandom));
            end else if (form == NAME_SHORT) begin
               repeat ($urandom_range(1, frpc_pkg::HB_LEN - 1)) void'(name_buf.pop_back());
            end
         end
      endcase
   endtask

   // Well-formed frame around whatever name_buf holds
   task automatic add_frame(input logic [15:0] msg_type, input logic [31:0] seq_id,
                            input int body_len, input logic [15:0] version);
      add_header(32'(frpc_pkg::HDR_BYTES + name_buf.size() + body_len), version, msg_type,
                 32'(name_buf.size()));
      foreach (name_buf[i]) push_byte(name_buf[i]);
      push_word(seq_id, 4);
      repeat (body_len) push_byte(8'($urandom));
      name_buf.delete();
   endtask

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= REPORT_LINES) begin
         $display("%0t ns: response %0d %s: got %0h, expected %0h",
                  $realtime, rsp_seen, what, got, want);
      end
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch(what, got, want);
      end
   endtask

   // Everything is sampled on the rising edge. Responses are checked before the
   // new request is modeled, so a response always meets an older expectation.
   always @(posedge clock) begin
      frpc_pkg::rsp_payload_type got;
      frpc_pkg::rsp_payload_type want;

      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            rsp_seen++;
            got = rsp_chan.payload;
            if (tags_due.size() == 0) begin
               report_mismatch("unexpected transaction", 32'(got.out_byte), '0);
            end else begin
               want = tags_due.pop_front();
               check_field("out_byte",     32'(got.out_byte),     32'(want.out_byte));
               check_field("byte_role",    32'(got.byte_role),    32'(want.byte_role));
               check_field("frame_kind",   32'(got.frame_kind),   32'(want.frame_kind));
               check_field("is_heartbeat", 32'(got.is_heartbeat), 32'(want.is_heartbeat));
               check_field("sequence_id",  got.sequence_id,       want.sequence_id);
               check_field("frame_end",    32'(got.frame_end),    32'(want.frame_end));
               check_field("status",       32'(got.status),       32'(want.status));
            end
         end
         if (!reset && req_chan.valid && req_chan.ready) begin
            parse_byte(req_chan.payload.data_byte);
         end
         req_fire <= !reset && req_chan.valid && req_chan.ready;
      end
   end

   // ------------------------------------------------------------------------
   // Driver: bursts of random length, random gaps, and a full pause before
   // any byte marked drain_first. Valid holds until the transaction is taken.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      logic offer;

      if (req_fire) begin
         void'(stream_bytes.pop_front());
      end
      if (!reset && (!req_chan.valid || req_fire)) begin
         offer = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (stream_bytes.size() != 0 &&
                      !(stream_bytes[0].drain_first && tags_due.size() != 0)) begin
            offer = 1'b1;
            req_chan.payload.data_byte <= stream_bytes[0].data;
            burst_left--;
            if (burst_left <= 0) begin
               // now and then a long stretch with no gaps at all
               burst_left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(40, 120))
                                                        : int'($urandom_range(1, 16));
               gap_left   = int'($urandom_range(1, 8));
            end
         end
         req_chan.valid <= offer;
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: 16-bit stall masks of varying density, plus one long hold-off
   // that lets the block fill up and push back on the sender.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      logic take;

      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (!hold_done && rsp_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
         end else begin
            if (stall_phase == 0) begin
               case ($urandom_range(0, 3))
                  0:       stall_mask = '1;
                  1:       stall_mask = 16'($urandom);
                  2:       stall_mask = 16'($urandom | $urandom);
                  default: stall_mask = 16'($urandom & $urandom);
               endcase
            end
            take        = stall_mask[stall_phase];
            stall_phase = stall_phase + 1'b1;
         end
         rsp_chan.ready <= take;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of test
   // ------------------------------------------------------------------------
   initial begin
      logic [15:0] msg_type;
      logic [31:0] bad_size;
      logic [31:0] bad_mlen;
      int          pick;
      int          body_len;

      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      restart_frame();
      err_code = frpc_pkg::STAT_OK;

      // Directed frames: every type, empty name and/or body, name edge cases,
      // extreme sequence ids and versions.
      make_name(NAME_HEARTBEAT);
      add_frame(frpc_pkg::T_CALL, 32'hFFFF_FFFF, 0, 16'h0000);
      make_name(NAME_EMPTY);
      add_frame(frpc_pkg::T_REPLY, 32'h0000_0000, 3, 16'hFFFF);
      make_name(NAME_EMPTY);
      add_frame(frpc_pkg::T_NOTIFY, 32'h0102_0304, 0, 16'($urandom));
      make_name(NAME_ALTERED);
      add_frame(frpc_pkg::T_NOTIFY, 32'h8000_0001, 2, 16'($urandom));
      make_name(NAME_LONG);
      add_frame(frpc_pkg::T_CALL, $urandom, 1, 16'($urandom));
      make_name(NAME_SHORT);
      add_frame(frpc_pkg::T_REPLY, $urandom, 4, 16'($urandom));
      // bytes on both sides of the upper-case range
      name_buf = {8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B};
      add_frame(frpc_pkg::T_CALL, $urandom, 2, 16'($urandom));
      make_name(NAME_HEARTBEAT);
      add_frame(frpc_pkg::T_REPLY, $urandom, 5, 16'($urandom));

      // Sender waits for the block to drain before the random part
      drain_next = 1'b1;
      while (stream_bytes.size() < STREAM_BYTES) begin
         if ($urandom_range(0, 9) == 0) begin
            drain_next = 1'b1;
         end
         pick = int'($urandom_range(0, 9));
         case (pick)
            0:       make_name(NAME_EMPTY);
            1, 2, 3: make_name(NAME_HEARTBEAT);
            4:       make_name(NAME_ALTERED);
            5:       make_name(NAME_LONG);
            6:       make_name(NAME_SHORT);
            default: make_name(NAME_RANDOM);
         endcase
         case ($urandom_range(0, 2))
            0:       msg_type = frpc_pkg::T_CALL;
            1:       msg_type = frpc_pkg::T_REPLY;
            default: msg_type = frpc_pkg::T_NOTIFY;
         endcase
         if ($urandom_range(0, 3) == 0) begin
            body_len = 0;
         end else if ($urandom_range(0, 9) == 0) begin
            body_len = int'($urandom_range(20, 60));
         end else begin
            body_len = int'($urandom_range(1, 12));
         end
         add_frame(msg_type, $urandom, body_len, 16'($urandom));
      end

      // The error is sticky until reset, so one broken frame closes the run,
      // followed by noise that must all be discarded.
      if ($urandom_range(0, 1) == 0) begin
         msg_type = 16'($urandom);
         if (msg_type == frpc_pkg::T_CALL || msg_type == frpc_pkg::T_REPLY ||
             msg_type == frpc_pkg::T_NOTIFY) begin
            msg_type = msg_type ^ 16'h8000;
         end
         add_header($urandom_range(12, 40), 16'($urandom), msg_type, $urandom_range(0, 8));
      end else begin
         if ($urandom_range(0, 3) == 0) begin
            // would pass if 12 + method length wrapped at 32 bits
            bad_size = 32'hFFFF_FFFF;
            bad_mlen = 32'hFFFF_FFF4;
         end else begin
            bad_size = $urandom_range(0, 40);
            bad_mlen = (bad_size < frpc_pkg::HDR_BYTES) ?
                       $urandom_range(0, 8) :
                       bad_size - frpc_pkg::HDR_BYTES + $urandom_range(1, 6);
         end
         add_header(bad_size, 16'($urandom), frpc_pkg::T_CALL, bad_mlen);
      end
      repeat ($urandom_range(8, 30)) push_byte(8'($urandom));

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      while (stream_bytes.size() != 0) @(posedge clock);
      while (tags_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== framed_rpc_message_parser_unit.f =====
hdl/frpc_pkg.sv
hdl/frpc_stream_if.sv
hdl/framed_rpc_message_parser_unit.sv
dv/framed_rpc_message_parser_unit_test.sv
